@@ rtl/assert_macros.svh @@
// Assertion macros used by the RTL controller of the tracking filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/tft_pkg.sv @@
// Shared types, constants and saturation helper of the temperature tracking filter.
`timescale 1ns / 1ps

package tft_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int SCALED_W   = 18;   // sample times 64
    localparam int VAL_W      = 24;
    localparam int GAIN_W     = 17;
    localparam int THR_W      = 23;
    localparam int INV_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 23;
    localparam int DELTA_W    = 25;
    localparam int MB_W       = 18;
    localparam int PROD_W     = 42;
    localparam int WIDE_W     = 34;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_K     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_PERIOD = 2'd2;

    localparam logic [GAIN_W-1:0] GAIN_RST = 17'd49152;
    localparam logic [GAIN_W-1:0] GAIN_ONE = 17'd65536;
    localparam logic [THR_W-1:0]  THR_RST  = 23'd2560;
    localparam logic [INV_W-1:0]  INV_RST  = 16'd256;

    localparam logic signed [WIDE_W-1:0] WIDE_MAX = 34'sd8388607;
    localparam logic signed [WIDE_W-1:0] WIDE_MIN = -34'sd8388608;
    localparam logic signed [VAL_W-1:0]  VAL_MAX  = 24'sh7FFFFF;
    localparam logic signed [VAL_W-1:0]  VAL_MIN  = 24'sh800000;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_k;
        logic [THR_W-1:0]  threshold;
        logic [INV_W-1:0]  inv_period;
    } tft_cfg_t;

    typedef struct packed {
        logic load_in;
        logic prep;
        logic mul;
        logic upd;
        logic rate;
        logic load_out;
    } tft_cmd_t;

    function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [WIDE_W-1:0] v);
        logic signed [VAL_W-1:0] r;
        if (v > WIDE_MAX)
        begin
            r = VAL_MAX;
        end
        else if (v < WIDE_MIN)
        begin
            r = VAL_MIN;
        end
        else
        begin
            r = v[VAL_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/tft_cfg.sv @@
// Configuration register file: gain, outlier threshold and inverse sample period.
`timescale 1ns / 1ps

module tft_cfg
    import tft_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output tft_cfg_t              cfg
);

    tft_cfg_t cfg_reg;
    tft_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_GAIN_K:     cfg_next.gain_k     = cfg_data[GAIN_W-1:0];
                CFG_THRESHOLD:  cfg_next.threshold  = cfg_data[THR_W-1:0];
                CFG_INV_PERIOD: cfg_next.inv_period = cfg_data[INV_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_k     <= GAIN_RST;
            cfg_reg.threshold  <= THR_RST;
            cfg_reg.inv_period <= INV_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ rtl/tft_dp.sv @@
// Datapath: filter state, prediction, shared multiplier, rounding and result registers.
`timescale 1ns / 1ps

module tft_dp
    import tft_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  tft_cmd_t                cmd,
    input  tft_cfg_t                cfg,
    input  logic                    command,
    input  logic [SAMPLE_W-1:0]     sample,
    input  logic                    sample_valid,
    output logic signed [VAL_W-1:0] estimate,
    output logic                    estimate_ok,
    output logic signed [VAL_W-1:0] rate
);

    // Latched input word
    logic                    cmd_reset_reg;
    logic [SCALED_W-1:0]     s_reg;
    logic                    sv_reg;

    // Filter state
    logic signed [VAL_W-1:0] est_reg, est_next;
    logic                    known_reg, known_next;
    logic signed [VAL_W-1:0] step_reg, step_next;

    // Intermediate values
    logic signed [VAL_W-1:0]  est_eff_reg;
    logic signed [VAL_W-1:0]  pred_reg;
    logic                     inlier_reg;
    logic signed [PROD_W-1:0] prod_reg;

    // Result word
    logic signed [VAL_W-1:0] est_out_reg;
    logic                    ok_out_reg;
    logic signed [VAL_W-1:0] rate_out_reg;

    logic signed [DELTA_W-1:0]       s_ext;
    logic signed [VAL_W-1:0]         est_eff_w;
    logic signed [VAL_W-1:0]         pred_w;
    logic signed [DELTA_W-1:0]       dist_s;
    logic [DELTA_W-1:0]              dist_abs;
    logic                            inlier_w;
    logic [GAIN_W-1:0]               k_w;
    logic signed [DELTA_W-1:0]       mul_a;
    logic signed [MB_W-1:0]          mul_b;
    logic signed [DELTA_W+MB_W-1:0]  prod_full;
    logic signed [PROD_W-1:0]        blend_sum;
    logic signed [PROD_W-1:0]        rate_sum;
    logic signed [WIDE_W-1:0]        nv_wide;
    logic signed [VAL_W-1:0]         nv_w;
    logic signed [VAL_W-1:0]         step_new_w;
    logic signed [VAL_W-1:0]         rate_w;

    assign s_ext = $signed({{(DELTA_W-SCALED_W){1'b0}}, s_reg});

    // An estimate that holds no number yet takes the sample before predicting.
    assign est_eff_w = known_reg ? est_reg : s_ext[VAL_W-1:0];
    assign pred_w    = sat_val(WIDE_W'(est_eff_w) + WIDE_W'(step_reg));
    assign dist_s    = s_ext - DELTA_W'(est_eff_w);
    assign dist_abs  = dist_s[DELTA_W-1] ? DELTA_W'(-dist_s) : DELTA_W'(dist_s);
    assign inlier_w  = dist_abs < {{(DELTA_W-THR_W){1'b0}}, cfg.threshold};

    assign k_w = cfg.gain_k[GAIN_W-1] ? GAIN_ONE : cfg.gain_k;

    // One multiplier serves the blend (prediction minus sample, times gain)
    // and the rate scaling (change per sample, times inverse period).
    always_comb
    begin
        if (cmd.rate)
        begin
            mul_a = DELTA_W'(step_reg);
            mul_b = $signed({{(MB_W-INV_W){1'b0}}, cfg.inv_period});
        end
        else
        begin
            mul_a = DELTA_W'(pred_reg) - s_ext;
            mul_b = $signed({{(MB_W-GAIN_W){1'b0}}, k_w});
        end
    end

    assign prod_full = mul_a * mul_b;

    // new = s + floor((delta * k + half) / 65536)
    assign blend_sum  = (prod_reg + PROD_W'(32768)) >>> 16;
    assign nv_wide    = WIDE_W'(blend_sum[WIDE_W-1:0]) + WIDE_W'(s_ext);
    assign nv_w       = sat_val(nv_wide);
    assign step_new_w = sat_val(WIDE_W'(nv_w) - WIDE_W'(est_eff_reg));

    assign rate_sum = (prod_reg + PROD_W'(128)) >>> 8;
    assign rate_w   = sat_val(rate_sum[WIDE_W-1:0]);

    always_comb
    begin
        est_next   = est_reg;
        known_next = known_reg;
        step_next  = step_reg;
        if (cmd.upd && sv_reg)
        begin
            known_next = 1'b1;
            if (cmd_reset_reg)
            begin
                est_next  = s_ext[VAL_W-1:0];
                step_next = '0;
            end
            else if (inlier_reg)
            begin
                est_next  = nv_w;
                step_next = step_new_w;
            end
            else
            begin
                est_next = pred_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            est_reg   <= '0;
            known_reg <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            est_reg   <= est_next;
            known_reg <= known_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            cmd_reset_reg <= command;
            s_reg         <= {sample, 6'b0};
            sv_reg        <= sample_valid;
        end
        if (cmd.prep)
        begin
            est_eff_reg <= est_eff_w;
            pred_reg    <= pred_w;
            inlier_reg  <= inlier_w;
        end
        if (cmd.mul || cmd.rate)
        begin
            prod_reg <= prod_full[PROD_W-1:0];
        end
        if (cmd.load_out)
        begin
            est_out_reg  <= known_reg ? est_reg : '0;
            ok_out_reg   <= known_reg;
            rate_out_reg <= rate_w;
        end
    end

    assign estimate    = est_out_reg;
    assign estimate_ok = ok_out_reg;
    assign rate        = rate_out_reg;

endmodule

@@ rtl/tft_ctrl.sv @@
// Controller: sequences one word through the datapath and owns the result handshake.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tft_ctrl
    import tft_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_ready,
    output logic     result_valid,
    input  logic     result_ready,
    output tft_cmd_t cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_UPD  = 3'd3;
    localparam logic [2:0] S_RATE = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       result_valid_reg, result_valid_next;

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;

    always_comb
    begin
        cmd          = '0;
        cmd.load_in  = item_valid && (state_reg == S_IDLE);
        cmd.prep     = (state_reg == S_PREP);
        cmd.mul      = (state_reg == S_MUL);
        cmd.upd      = (state_reg == S_UPD);
        cmd.rate     = (state_reg == S_RATE);
        // The result register is reloaded only once the previous word has gone.
        cmd.load_out = (state_reg == S_OUT) && (!result_valid_reg || result_ready);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:  state_next = S_MUL;
            S_MUL:   state_next = S_UPD;
            S_UPD:   state_next = S_RATE;
            S_RATE:  state_next = S_OUT;
            S_OUT:
            begin
                if (cmd.load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (cmd.load_out)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    `ASSERT_CLK(a_cmd_exclusive, $onehot0(cmd), "two datapath commands in one cycle")
    `ASSERT_CLK(a_accept_starts, (item_valid && item_ready) |=> (state_reg == S_PREP), "accepted word did not start")
    `ASSERT_CLK(a_out_free, cmd.load_out |-> (!result_valid || result_ready), "result overwritten before taken")
    `ASSERT_CLK(a_upd_then_rate, cmd.upd |=> cmd.rate, "rate not scaled after state update")

endmodule

@@ rtl/temperature_tracking_filter_unit.sv @@
// Top level of the temperature tracking filter: configuration, controller and datapath.
//
//  channel  direction  handshake                  payload
//  item     in         item_valid / item_ready    command, sample, sample_valid
//  result   out        result_valid / result_ready estimate, estimate_ok, rate
//  cfg      in         cfg_valid / cfg_ready      cfg_index, cfg_data
//
// Each word passes through acceptance, then prediction, multiply, state update,
// rate multiply and result load; the two multiplies share one 25x18 multiplier.
// A new word is accepted once the previous one has reached the result register,
// so a held result stalls the unit only when a second result is ready behind it.
// Reset clears the estimate, its validity and the change, and loads the default configuration.
// Configuration writes are accepted in every cycle.
`timescale 1ns / 1ps

module temperature_tracking_filter_unit
    import tft_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    output logic                    item_ready,
    input  logic                    command,
    input  logic [SAMPLE_W-1:0]     sample,
    input  logic                    sample_valid,
    output logic                    result_valid,
    input  logic                    result_ready,
    output logic signed [VAL_W-1:0] estimate,
    output logic                    estimate_ok,
    output logic signed [VAL_W-1:0] rate,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    tft_cfg_t cfg;
    tft_cmd_t cmd;

    tft_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tft_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cmd          (cmd)
    );

    tft_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg          (cfg),
        .command      (command),
        .sample       (sample),
        .sample_valid (sample_valid),
        .estimate     (estimate),
        .estimate_ok  (estimate_ok),
        .rate         (rate)
    );

endmodule

@@ dv/tb_temperature_tracking_filter_unit.sv @@
// Self-checking testbench for the temperature tracking filter unit.
`timescale 1ns / 1ps

module tb_temperature_tracking_filter_unit
    import tft_pkg::*;
();

    localparam logic CMD_FILTER = 1'b0;
    localparam logic CMD_RESET  = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam longint UNIT_ONE = 65536;

    typedef struct {
        logic signed [VAL_W-1:0] est;
        logic                    ok;
        logic signed [VAL_W-1:0] slope;
    } filt_result_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    item_valid;
    logic                    item_ready;
    logic                    command;
    logic [SAMPLE_W-1:0]     sample;
    logic                    sample_valid;
    logic                    result_valid;
    logic                    result_ready;
    logic signed [VAL_W-1:0] estimate;
    logic                    estimate_ok;
    logic signed [VAL_W-1:0] rate;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    // Shadow copy of the filter state and its registers.
    logic signed [VAL_W-1:0] track_est;
    logic                    track_known;
    logic signed [VAL_W-1:0] track_step;
    logic [GAIN_W-1:0]       gain_reg;
    logic [THR_W-1:0]        thr_reg;
    logic [INV_W-1:0]        inv_reg;

    filt_result_t expected_results[$];
    int error_count = 0;
    int tx_idle_pct = 15;
    int rx_idle_pct = 78;
    int hold_len = 0;
    logic hold_request = 1'b0;
    int rx_hold_left = 0;
    int walk_sample = 2000;

    temperature_tracking_filter_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .command      (command),
        .sample       (sample),
        .sample_valid (sample_valid),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .estimate     (estimate),
        .estimate_ok  (estimate_ok),
        .rate         (rate),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    initial
    begin
        #2000000;
        $display("tb_temperature_tracking_filter_unit NOT OK");
        $finish;
    end

    function automatic logic signed [VAL_W-1:0] clamp24(input longint v);
        logic signed [VAL_W-1:0] r;
        if (v > 64'sd8388607)
        begin
            r = VAL_MAX;
        end
        else if (v < -64'sd8388608)
        begin
            r = VAL_MIN;
        end
        else
        begin
            r = v[VAL_W-1:0];
        end
        return r;
    endfunction

    // Advances the shadow filter by one word and queues the result it should give.
    task automatic track_word(input logic cmd, input logic [SAMPLE_W-1:0] smp,
                              input logic smp_ok);
        longint scaled;
        longint cur;
        longint pred;
        longint gap;
        longint k;
        longint acc;
        longint prod;
        logic signed [VAL_W-1:0] blended;
        filt_result_t res;
        scaled = longint'(smp) * 64;
        if (cmd == CMD_RESET)
        begin
            if (smp_ok)
            begin
                track_est   = scaled[VAL_W-1:0];
                track_known = 1'b1;
                track_step  = '0;
            end
        end
        else
        begin
            if (!track_known && smp_ok)
            begin
                track_est   = scaled[VAL_W-1:0];
                track_known = 1'b1;
            end
            if (smp_ok)
            begin
                cur  = track_est;
                pred = clamp24(cur + longint'(track_step));
                gap  = scaled - cur;
                if (gap < 0)
                begin
                    gap = -gap;
                end
                if (gap < longint'(thr_reg))
                begin
                    k = (gain_reg > GAIN_ONE) ? UNIT_ONE : longint'(gain_reg);
                    acc = pred * k + scaled * (UNIT_ONE - k);
                    blended = clamp24((acc + 32768) >>> 16);
                    track_step = clamp24(longint'(blended) - cur);
                    track_est  = blended;
                end
                else
                begin
                    track_est = pred[VAL_W-1:0];
                end
            end
        end
        prod = longint'(track_step) * longint'(inv_reg);
        res.slope = clamp24((prod + 128) >>> 8);
        res.est   = track_known ? track_est : '0;
        res.ok    = track_known;
        expected_results.push_back(res);
    endtask

    // Offers one word, with random idle cycles ahead of it, and waits for acceptance.
    task automatic send_word(input logic cmd, input logic [SAMPLE_W-1:0] smp,
                             input logic smp_ok);
        @(negedge clk);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            item_valid = 1'b0;
            @(negedge clk);
        end
        item_valid   = 1'b1;
        command      = cmd;
        sample       = smp;
        sample_valid = smp_ok;
        @(posedge clk);
        while (!item_ready)
        begin
            @(posedge clk);
        end
        track_word(cmd, smp, smp_ok);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        item_valid = 1'b0;
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        wait_drained();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        case (idx)
            CFG_GAIN_K:     gain_reg = val[GAIN_W-1:0];
            CFG_THRESHOLD:  thr_reg  = val[THR_W-1:0];
            CFG_INV_PERIOD: inv_reg  = val[INV_W-1:0];
            default:        ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Receiver side: random back-pressure, plus an optional long hold-off.
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            rx_hold_left = hold_len;
            hold_request = 1'b0;
        end
        if (rx_hold_left > 0)
        begin
            result_ready = 1'b0;
            rx_hold_left--;
        end
        else
        begin
            result_ready = ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        filt_result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, actual estimate %0d ok %0b rate %0d",
                         $time, estimate, estimate_ok, rate);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (estimate !== want.est)
                begin
                    $display("%0t: estimate mismatch, expected %0d, actual %0d",
                             $time, want.est, estimate);
                    error_count++;
                end
                if (estimate_ok !== want.ok)
                begin
                    $display("%0t: estimate_ok mismatch, expected %0b, actual %0b",
                             $time, want.ok, estimate_ok);
                    error_count++;
                end
                if (rate !== want.slope)
                begin
                    $display("%0t: rate mismatch, expected %0d, actual %0d",
                             $time, want.slope, rate);
                    error_count++;
                end
            end
        end
    end

    function automatic logic [SAMPLE_W-1:0] next_walk_sample();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
        begin
            walk_sample = walk_sample + $urandom_range(0, 24) - 12;
        end
        else if (pick < 90)
        begin
            walk_sample = $urandom_range(0, 4095);
        end
        else
        begin
            walk_sample = ($urandom_range(0, 1) != 0) ? 4095 : 0;
        end
        if (walk_sample < 0)
        begin
            walk_sample = 0;
        end
        if (walk_sample > 4095)
        begin
            walk_sample = 4095;
        end
        return walk_sample[SAMPLE_W-1:0];
    endfunction

    task automatic test_directed_basics();
        // Open probe before any number: the estimate stays unknown.
        send_word(CMD_FILTER, 12'd100, 1'b0);
        send_word(CMD_RESET, 12'd4095, 1'b0);
        send_word(CMD_FILTER, 12'd0, 1'b1);
        send_word(CMD_FILTER, 12'd4095, 1'b1);
        send_word(CMD_FILTER, 12'd10, 1'b1);
        send_word(CMD_FILTER, 12'd20, 1'b1);
        send_word(CMD_FILTER, 12'd35, 1'b1);
        send_word(CMD_RESET, 12'd4095, 1'b1);
        send_word(CMD_FILTER, 12'd4095, 1'b0);
        send_word(CMD_FILTER, 12'd4090, 1'b1);
        send_word(CMD_FILTER, 12'd4080, 1'b1);
        // A distance equal to the threshold counts as an outlier; one less is blended.
        send_word(CMD_RESET, 12'd1000, 1'b1);
        send_word(CMD_FILTER, 12'd1040, 1'b1);
        send_word(CMD_RESET, 12'd1000, 1'b1);
        send_word(CMD_FILTER, 12'd1039, 1'b1);
        send_word(CMD_FILTER, 12'd1030, 1'b1);
        send_word(CMD_RESET, 12'd0, 1'b1);
        send_word(CMD_FILTER, 12'd0, 1'b1);
        send_word(CMD_FILTER, 12'hAAA, 1'b1);
        send_word(CMD_FILTER, 12'h555, 1'b1);
    endtask

    task automatic test_config_extremes();
        write_reg(CFG_GAIN_K, 23'd0);
        send_word(CMD_RESET, 12'd2000, 1'b1);
        send_word(CMD_FILTER, 12'd2020, 1'b1);
        write_reg(CFG_GAIN_K, 23'd65536);
        send_word(CMD_FILTER, 12'd2030, 1'b1);
        send_word(CMD_FILTER, 12'd2000, 1'b1);
        // Gain above one behaves as exactly one.
        write_reg(CFG_GAIN_K, 23'd131071);
        send_word(CMD_FILTER, 12'd2010, 1'b1);
        write_reg(CFG_GAIN_K, 23'h7FFFFF);
        send_word(CMD_FILTER, 12'd1995, 1'b1);
        write_reg(CFG_GAIN_K, 23'd12345);
        write_reg(CFG_THRESHOLD, 23'd0);
        send_word(CMD_FILTER, 12'd2000, 1'b1);
        write_reg(CFG_THRESHOLD, 23'd8388607);
        send_word(CMD_FILTER, 12'd0, 1'b1);
        write_reg(CFG_INV_PERIOD, 23'd0);
        send_word(CMD_FILTER, 12'd100, 1'b1);
        write_reg(CFG_INV_PERIOD, 23'd65535);
        send_word(CMD_FILTER, 12'd4095, 1'b1);
        write_reg(CFG_INV_PERIOD, 23'd1);
        send_word(CMD_FILTER, 12'd3000, 1'b1);
        write_reg(CFG_UNUSED, 23'h5A5A5A);
        send_word(CMD_FILTER, 12'd3010, 1'b1);
    endtask

    task automatic test_saturation();
        write_reg(CFG_GAIN_K, 23'd0);
        write_reg(CFG_THRESHOLD, 23'd8388607);
        write_reg(CFG_INV_PERIOD, 23'd65535);
        send_word(CMD_RESET, 12'd0, 1'b1);
        send_word(CMD_FILTER, 12'd4095, 1'b1);
        // With every sample an outlier the estimate climbs by the full step until it clips.
        write_reg(CFG_THRESHOLD, 23'd0);
        repeat (34) send_word(CMD_FILTER, SAMPLE_W'($urandom_range(0, 4095)), 1'b1);
        write_reg(CFG_THRESHOLD, 23'd8388607);
        send_word(CMD_FILTER, 12'd0, 1'b1);
        write_reg(CFG_THRESHOLD, 23'd0);
        repeat (4) send_word(CMD_FILTER, SAMPLE_W'($urandom_range(0, 4095)), 1'b1);
    endtask

    task automatic randomise_config();
        case ($urandom_range(0, 4))
            0: write_reg(CFG_GAIN_K, 23'd0);
            1: write_reg(CFG_GAIN_K, 23'd65536);
            2: write_reg(CFG_GAIN_K, CFG_DATA_W'($urandom_range(65537, 131071)));
            default: write_reg(CFG_GAIN_K, CFG_DATA_W'($urandom_range(0, 65536)));
        endcase
        case ($urandom_range(0, 5))
            0: write_reg(CFG_THRESHOLD, 23'd0);
            1: write_reg(CFG_THRESHOLD, 23'd8388607);
            2: write_reg(CFG_THRESHOLD, 23'd2560);
            default: write_reg(CFG_THRESHOLD, CFG_DATA_W'($urandom_range(1, 20000)));
        endcase
        case ($urandom_range(0, 5))
            0: write_reg(CFG_INV_PERIOD, 23'd1);
            1: write_reg(CFG_INV_PERIOD, 23'd65535);
            2: write_reg(CFG_INV_PERIOD, 23'd0);
            default: write_reg(CFG_INV_PERIOD, CFG_DATA_W'($urandom_range(1, 65535)));
        endcase
    endtask

    task automatic test_random_phase(input int tx_pct, input int rx_pct, input int count);
        int pick;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int n = 0; n < count; n++)
        begin
            if (n % 50 == 0)
            begin
                randomise_config();
            end
            else if ($urandom_range(0, 99) < 2)
            begin
                wait_drained();
            end
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                send_word(CMD_FILTER, next_walk_sample(), 1'b1);
            end
            else if (pick < 80)
            begin
                send_word(CMD_RESET, next_walk_sample(), 1'b1);
            end
            else if (pick < 90)
            begin
                send_word(CMD_FILTER, SAMPLE_W'($urandom_range(0, 4095)), 1'b0);
            end
            else
            begin
                send_word(CMD_RESET, SAMPLE_W'($urandom_range(0, 4095)), 1'b0);
            end
        end
    endtask

    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        wait_drained();
        write_reg(CFG_GAIN_K, 23'd49152);
        write_reg(CFG_THRESHOLD, 23'd2560);
        write_reg(CFG_INV_PERIOD, 23'd256);
        hold_len = 300;
        hold_request = 1'b1;
        repeat (12) send_word(CMD_FILTER, next_walk_sample(), 1'b1);
        wait_drained();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        command      = CMD_FILTER;
        sample       = '0;
        sample_valid = 1'b0;
        result_ready = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_GAIN_K;
        cfg_data     = '0;
        track_est    = '0;
        track_known  = 1'b0;
        track_step   = '0;
        gain_reg     = GAIN_RST;
        thr_reg      = THR_RST;
        inv_reg      = INV_RST;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_basics();
        test_config_extremes();
        test_saturation();
        test_random_phase(15, 78, 125);
        test_random_phase(78, 15, 125);
        test_random_phase(0, 0, 125);
        test_backpressure();

        wait_drained();
        repeat (20) @(posedge clk);
        if (error_count == 0)
        begin
            $display("tb_temperature_tracking_filter_unit OK");
        end
        else
        begin
            $display("tb_temperature_tracking_filter_unit NOT OK");
        end
        $finish;
    end

endmodule
